// ===== hw/rtl/sts_pkg.sv =====
// Package with request, response and store types for the symbol table stack search unit.
`default_nettype none

package sts_pkg;

	typedef enum logic [2:0] {
		OP_PUSH    = 3'd0,
		OP_POP     = 3'd1,
		OP_REMOVE  = 3'd2,
		OP_SETTYPE = 3'd3,
		OP_SEARCH  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_MISS  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP_RD,
		ST_RETYPE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [63:0] symbol_name;
		logic [1:0]  symbol_category;
		logic [7:0]  nest_level;
		logic [1:0]  symbol_type;
		logic [31:0] extra_payload;
		logic [6:0]  entry_count;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  hit_index;
		logic [63:0] out_name;
		logic [1:0]  out_category;
		logic [7:0]  out_level;
		logic [1:0]  out_type;
		logic [31:0] out_payload;
		logic [6:0]  fill_count;
	} rsp_t;

	// One table entry as kept in the store
	typedef struct packed {
		logic [63:0] name;
		logic [1:0]  category;
		logic [7:0]  level;
		logic [1:0]  sym_type;
		logic [31:0] payload;
	} entry_t;

	// Store port controls
	typedef struct packed {
		logic entry_we;
		logic type_we;
		logic rd_en;
	} store_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sts_store.sv =====
// Entry store: name, attribute and type memories with one write and one registered read port.
`default_nettype none

module sts_store #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                           clk,
	input  wire sts_pkg::store_cmd_t            cmd,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  wire sts_pkg::entry_t                wr_data,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	output sts_pkg::entry_t                     rd_data
);

	logic [63:0] name_mem [TABLE_DEPTH];
	logic [41:0] attr_mem [TABLE_DEPTH];
	logic [1:0]  type_mem [TABLE_DEPTH];

	logic [63:0] name_q;
	logic [41:0] attr_q;
	logic [1:0]  type_q;

	// Write a whole entry on push, the type alone on retype
	always_ff @(posedge clk) begin
		if (cmd.entry_we) begin
			name_mem[wr_addr] <= wr_data.name;
			attr_mem[wr_addr] <= {wr_data.category, wr_data.level, wr_data.payload};
		end
		if (cmd.entry_we || cmd.type_we) begin
			type_mem[wr_addr] <= wr_data.sym_type;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			name_q <= name_mem[rd_addr];
			attr_q <= attr_mem[rd_addr];
			type_q <= type_mem[rd_addr];
		end
	end

	assign rd_data.name     = name_q;
	assign rd_data.category = attr_q[41:40];
	assign rd_data.level    = attr_q[39:32];
	assign rd_data.payload  = attr_q[31:0];
	assign rd_data.sym_type = type_q;

endmodule

`default_nettype wire

// ===== hw/rtl/symbol_table_stack_search_unit.sv =====
// Symbol table stack search unit: one request at a time, walked by a small sequencer.
// Push, remove, unused codes and empty tables go from execute straight to finish; pop adds
// a store read, set type rewrites n entries from the top down, and a search walks down from
// the top until a hit, or through every held entry on a miss; one store entry is walked
// per cycle. A request is taken the cycle after the last result enters the output register;
// output stalls hold the finish state. Reset clears count and control, not the memories.
`default_nettype none

module symbol_table_stack_search_unit #(
	parameter int TABLE_DEPTH = 64,
	parameter int NAME_BYTES  = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire sts_pkg::req_t req_data,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output sts_pkg::rsp_t      rsp_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int MW = (CW > 7) ? CW : 7;
	localparam logic [63:0] NAME_MASK = (NAME_BYTES >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * NAME_BYTES)) - 64'd1);

	sts_pkg::state_t     state_q, state_d;
	sts_pkg::req_t       req_q;
	sts_pkg::rsp_t       res_q;
	sts_pkg::rsp_t       out_q;
	logic                out_valid_q;
	logic [CW-1:0]       held_q;
	logic [CW-1:0]       left_q;
	logic [AW-1:0]       ptr_q;
	logic                more_q;
	logic [AW-1:0]       chk_idx_q;

	sts_pkg::store_cmd_t cmd;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;
	sts_pkg::entry_t     wr_data;
	sts_pkg::entry_t     rd_data;

	logic                held_zero;
	logic                full;
	logic [CW-1:0]       held_dec;
	logic [AW-1:0]       top_idx;
	logic [MW-1:0]       held_ext;
	logic [MW-1:0]       cnt_ext;
	logic [MW-1:0]       diff_ext;
	logic [CW-1:0]       retype_n;
	logic [CW-1:0]       remove_new;
	logic                match;
	logic                out_free;

	sts_pkg::req_t       req_in;
	sts_pkg::rsp_t       exec_res;
	sts_pkg::rsp_t       entry_res;
	sts_pkg::rsp_t       fin_res;
	logic [AW-1:0]       exec_ptr;

	// Derive table status and count arithmetic
	always_comb begin
		held_zero  = (held_q == '0);
		full       = (held_q == CW'(TABLE_DEPTH));
		held_dec   = held_q - CW'(1);
		top_idx    = held_dec[AW-1:0];
		held_ext   = MW'(held_q);
		cnt_ext    = MW'(req_q.entry_count);
		diff_ext   = held_ext - cnt_ext;
		retype_n   = (cnt_ext > held_ext) ? held_q : CW'(req_q.entry_count);
		remove_new = (cnt_ext >= held_ext) ? '0 : diff_ext[CW-1:0];
		match      = (rd_data.name == req_q.symbol_name);
		out_free   = !out_valid_q || rsp_ready;
	end

	// Form the masked request and the result words for each step
	always_comb begin
		req_in             = req_data;
		req_in.symbol_name = req_data.symbol_name & NAME_MASK;

		exec_res = '0;
		exec_ptr = top_idx;
		case (req_q.opcode)
			sts_pkg::OP_PUSH: begin
				if (full) exec_res.status = sts_pkg::STAT_FULL;
				else      exec_res.hit_index = 6'(held_q);
			end
			sts_pkg::OP_POP, sts_pkg::OP_REMOVE, sts_pkg::OP_SETTYPE: begin
				if (held_zero) exec_res.status = sts_pkg::STAT_EMPTY;
			end
			sts_pkg::OP_SEARCH: begin
				exec_res.status = sts_pkg::STAT_MISS;
				exec_ptr        = top_idx - AW'(1);
			end
			default: ;
		endcase

		entry_res              = res_q;
		entry_res.status       = sts_pkg::STAT_OK;
		entry_res.hit_index    = 6'(chk_idx_q);
		entry_res.out_name     = rd_data.name;
		entry_res.out_category = rd_data.category;
		entry_res.out_level    = rd_data.level;
		entry_res.out_type     = rd_data.sym_type;
		entry_res.out_payload  = rd_data.payload;

		fin_res            = res_q;
		fin_res.fill_count = 7'(held_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sts_pkg::ST_IDLE: begin
				if (req_valid) state_d = sts_pkg::ST_EXEC;
			end
			sts_pkg::ST_EXEC: begin
				case (req_q.opcode)
					sts_pkg::OP_POP:
						state_d = held_zero ? sts_pkg::ST_FINISH : sts_pkg::ST_POP_RD;
					sts_pkg::OP_SETTYPE:
						state_d = (held_zero || retype_n == '0) ? sts_pkg::ST_FINISH :
							sts_pkg::ST_RETYPE;
					sts_pkg::OP_SEARCH:
						state_d = held_zero ? sts_pkg::ST_FINISH : sts_pkg::ST_SCAN;
					default:
						state_d = sts_pkg::ST_FINISH;
				endcase
			end
			sts_pkg::ST_POP_RD: begin
				state_d = sts_pkg::ST_FINISH;
			end
			sts_pkg::ST_RETYPE: begin
				if (left_q == CW'(1)) state_d = sts_pkg::ST_FINISH;
			end
			sts_pkg::ST_SCAN: begin
				if (match || chk_idx_q == '0) state_d = sts_pkg::ST_FINISH;
			end
			sts_pkg::ST_FINISH: begin
				if (out_free) state_d = sts_pkg::ST_IDLE;
			end
			default: state_d = sts_pkg::ST_IDLE;
		endcase
	end

	// Store controls and handshake outputs
	always_comb begin
		cmd              = '0;
		wr_addr          = ptr_q;
		rd_addr          = ptr_q;
		wr_data.name     = req_q.symbol_name;
		wr_data.category = req_q.symbol_category;
		wr_data.level    = req_q.nest_level;
		wr_data.sym_type = req_q.symbol_type;
		wr_data.payload  = req_q.extra_payload;
		req_ready        = (state_q == sts_pkg::ST_IDLE);
		unique case (state_q)
			sts_pkg::ST_EXEC: begin
				case (req_q.opcode)
					sts_pkg::OP_PUSH: begin
						cmd.entry_we = !full;
						wr_addr      = held_q[AW-1:0];
					end
					sts_pkg::OP_POP, sts_pkg::OP_SEARCH: begin
						cmd.rd_en = !held_zero;
						rd_addr   = top_idx;
					end
					default: ;
				endcase
			end
			sts_pkg::ST_RETYPE: begin
				cmd.type_we = 1'b1;
			end
			sts_pkg::ST_SCAN: begin
				cmd.rd_en = more_q;
			end
			default: ;
		endcase
	end

	sts_store #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_store (
		.clk    (clk),
		.cmd    (cmd),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sts_pkg::ST_IDLE;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sts_pkg::ST_EXEC && !held_zero) begin
				case (req_q.opcode)
					sts_pkg::OP_POP:    held_q <= held_dec;
					sts_pkg::OP_REMOVE: held_q <= remove_new;
					default: ;
				endcase
			end
			if (state_q == sts_pkg::ST_EXEC && req_q.opcode == sts_pkg::OP_PUSH && !full) begin
				held_q <= held_q + CW'(1);
			end
			if (state_q == sts_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request latch, walk pointers and result assembly
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req_in;
		end
		unique case (state_q)
			sts_pkg::ST_EXEC: begin
				res_q     <= exec_res;
				ptr_q     <= exec_ptr;
				left_q    <= retype_n;
				chk_idx_q <= top_idx;
				more_q    <= (top_idx != '0);
			end
			sts_pkg::ST_POP_RD: begin
				res_q <= entry_res;
			end
			sts_pkg::ST_RETYPE: begin
				ptr_q  <= ptr_q - AW'(1);
				left_q <= left_q - CW'(1);
			end
			sts_pkg::ST_SCAN: begin
				// Issue the next read while checking the previous one
				if (more_q) begin
					ptr_q     <= ptr_q - AW'(1);
					more_q    <= (ptr_q != '0);
					chk_idx_q <= ptr_q;
				end
				if (match) begin
					res_q <= entry_res;
				end
			end
			default: ;
		endcase
		// Move the finished result to the output register
		if (state_q == sts_pkg::ST_FINISH && out_free) begin
			out_q <= fin_res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

`default_nettype wire
